### rtl/sac_pkg.sv
// ----------------------------------------------------------------------------
// sac_pkg
// shared types and constants of the set-associative cache hit model
// ----------------------------------------------------------------------------
package sac_pkg;

  // parameter defaults
  localparam int MAX_SETS_DEF  = 256;
  localparam int MAX_WAYS_DEF  = 8;
  localparam int ADDR_BITS_DEF = 32;

  // fixed field widths
  localparam int ADDR_W     = 32;
  localparam int WAY_OUT_W  = 3;
  localparam int CNT_W      = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 4;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_LINE_LOG2 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SETS_LOG2 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WAYS      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_POLICY    = 3'd3;

  // replacement policy codes
  localparam logic POL_FIFO = 1'b0;
  localparam logic POL_LRU  = 1'b1;

  typedef struct packed {
    logic [3:0] line_log2;
    logic [3:0] sets_log2;
    logic [3:0] ways;
    logic       policy;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{line_log2: 4'd4, sets_log2: 4'd6, ways: 4'd4,
                                 policy: POL_FIFO};

endpackage

### rtl/sac_front.sv
// ----------------------------------------------------------------------------
// sac_front
// input side: takes an address beat, trims it and works out its set index
// ----------------------------------------------------------------------------
module sac_front #(
  parameter int  MAX_SETS  = sac_pkg::MAX_SETS_DEF,
  parameter int  ADDR_BITS = sac_pkg::ADDR_BITS_DEF,
  localparam int TAG_W     = (ADDR_BITS < sac_pkg::ADDR_W) ? ADDR_BITS : sac_pkg::ADDR_W,
  localparam int SET_W     = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1
) (
  input  sac_pkg::cfg_t                 cfg,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [sac_pkg::ADDR_W-1:0]    address,
  input  logic                          q_full,
  input  logic                          clearing,
  output logic                          q_push,
  output logic [SET_W+TAG_W-1:0]        q_item
);

  localparam int SLOG_MAX = $clog2(MAX_SETS + 1) - 1;

  logic [TAG_W-1:0] addr_m;
  logic [TAG_W-1:0] blk;
  logic [3:0]       s_eff;
  logic [SET_W-1:0] set_mask;
  logic [SET_W-1:0] set_idx;

  always_comb begin
    addr_m   = address[TAG_W-1:0];
    blk      = addr_m >> cfg.line_log2;
    // set count capped at the largest power of two that fits
    s_eff    = (cfg.sets_log2 > 4'(SLOG_MAX)) ? 4'(SLOG_MAX) : cfg.sets_log2;
    set_mask = ~({SET_W{1'b1}} << s_eff);
    set_idx  = blk[SET_W-1:0] & set_mask;
  end

  assign in_stall = q_full | clearing;
  assign q_push   = in_valid & ~in_stall;
  assign q_item   = {set_idx, addr_m};

endmodule

### rtl/sac_queue.sv
// ----------------------------------------------------------------------------
// sac_queue
// two-entry queue between the front and back parts
// ----------------------------------------------------------------------------
module sac_queue #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] dout,
  output logic             empty
);

  logic [WIDTH-1:0] slot [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       count;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= din;
    end
  end

  assign full  = (count == 2'd2);
  assign empty = (count == 2'd0);
  assign dout  = slot[rd_ptr];

endmodule

### rtl/sac_back.sv
// ----------------------------------------------------------------------------
// sac_back
// back side: reads a set row, compares tags, writes the row back, counts
// ----------------------------------------------------------------------------
module sac_back #(
  parameter int  MAX_SETS  = sac_pkg::MAX_SETS_DEF,
  parameter int  MAX_WAYS  = sac_pkg::MAX_WAYS_DEF,
  parameter int  ADDR_BITS = sac_pkg::ADDR_BITS_DEF,
  localparam int TAG_W     = (ADDR_BITS < sac_pkg::ADDR_W) ? ADDR_BITS : sac_pkg::ADDR_W,
  localparam int SET_W     = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1
) (
  input  logic                           clk,
  input  logic                           rst,
  input  sac_pkg::cfg_t                  cfg,
  input  logic                           q_empty,
  input  logic [SET_W+TAG_W-1:0]         q_item,
  output logic                           q_pop,
  output logic                           clearing,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic                           hit,
  output logic [sac_pkg::WAY_OUT_W-1:0]  way_used,
  output logic [sac_pkg::CNT_W-1:0]      hits_so_far,
  output logic [sac_pkg::CNT_W-1:0]      misses_so_far
);

  localparam int WAY_W  = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int TAGS_W = MAX_WAYS * TAG_W;
  localparam int VLD_LO = TAGS_W;
  localparam int PTR_LO = TAGS_W + MAX_WAYS;
  localparam int ROW_W  = TAGS_W + MAX_WAYS + WAY_W;

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_CMP   = 2'd2;

  logic [1:0]       state;
  logic [SET_W-1:0] clr_idx;
  logic [TAG_W-1:0] cur_addr;
  logic [SET_W-1:0] cur_set;

  logic [ROW_W-1:0] row_mem [MAX_SETS];
  logic [ROW_W-1:0] rd_row;

  logic             mem_we;
  logic [SET_W-1:0] mem_waddr;
  logic [ROW_W-1:0] mem_wdata;
  logic             commit;

  // row compare and update
  logic [TAG_W-1:0]    tag     [MAX_WAYS];
  logic [TAG_W-1:0]    new_tag [MAX_WAYS];
  logic [MAX_WAYS-1:0] vld;
  logic [MAX_WAYS-1:0] new_vld;
  logic [WAY_W-1:0]    ptr;
  logic [WAY_W-1:0]    new_ptr;
  logic [WAY_W-1:0]    fill_way;
  logic [4:0]          fill_inc;
  logic [3:0]          nw;
  logic [TAG_W-1:0]    hi_mask;
  logic                is_hit;
  logic [WAY_W-1:0]    hit_way;
  logic [WAY_W-1:0]    way;
  logic [ROW_W-1:0]    new_row;

  always_comb begin
    for (int i = 0; i < MAX_WAYS; i++) begin
      tag[i] = rd_row[i*TAG_W +: TAG_W];
    end
    vld     = rd_row[VLD_LO +: MAX_WAYS];
    ptr     = rd_row[PTR_LO +: WAY_W];
    hi_mask = {TAG_W{1'b1}} << cfg.line_log2;

    // ways in use: zero acts as one, capped at the array size
    if (cfg.ways == 4'd0) begin
      nw = 4'd1;
    end else if ({1'b0, cfg.ways} > 5'(MAX_WAYS)) begin
      nw = 4'(MAX_WAYS);
    end else begin
      nw = cfg.ways;
    end

    // highest matching way wins
    is_hit  = 1'b0;
    hit_way = '0;
    for (int i = 0; i < MAX_WAYS; i++) begin
      if ((5'(i) < {1'b0, nw}) && vld[i] && (((tag[i] ^ cur_addr) & hi_mask) == '0)) begin
        is_hit  = 1'b1;
        hit_way = WAY_W'(i);
      end
    end

    // round-robin fill slot, back to way 0 if out of range
    fill_way = (5'(ptr) >= {1'b0, nw}) ? '0 : ptr;
    fill_inc = 5'(fill_way) + 5'd1;

    for (int i = 0; i < MAX_WAYS; i++) begin
      new_tag[i] = tag[i];
    end
    new_vld = vld;
    new_ptr = ptr;
    way     = hit_way;

    if (cfg.policy == sac_pkg::POL_FIFO) begin
      if (!is_hit) begin
        for (int i = 0; i < MAX_WAYS; i++) begin
          if (WAY_W'(i) == fill_way) begin
            new_tag[i] = cur_addr;
            new_vld[i] = 1'b1;
          end
        end
        new_ptr = (fill_inc == {1'b0, nw}) ? '0 : WAY_W'(fill_inc);
        way     = fill_way;
      end
    end else begin
      if (is_hit) begin
        // move the hit entry to the front, shift only the ones ahead of it
        for (int i = 1; i < MAX_WAYS; i++) begin
          if (WAY_W'(i) <= hit_way) begin
            new_tag[i] = tag[i-1];
            new_vld[i] = vld[i-1];
          end
        end
        new_tag[0] = tag[hit_way];
        new_vld[0] = 1'b1;
      end else begin
        for (int i = 1; i < MAX_WAYS; i++) begin
          if (5'(i) < {1'b0, nw}) begin
            new_tag[i] = tag[i-1];
            new_vld[i] = vld[i-1];
          end
        end
        new_tag[0] = cur_addr;
        new_vld[0] = 1'b1;
        way        = '0;
      end
    end

    for (int i = 0; i < MAX_WAYS; i++) begin
      new_row[i*TAG_W +: TAG_W] = new_tag[i];
    end
    new_row[VLD_LO +: MAX_WAYS] = new_vld;
    new_row[PTR_LO +: WAY_W]    = new_ptr;
  end

  assign clearing = (state == ST_CLEAR);
  assign q_pop    = (state == ST_IDLE) && !q_empty;
  assign commit   = (state == ST_CMP) && (!out_valid || !out_stall);

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = cur_set;
    mem_wdata = new_row;
    if (state == ST_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_idx;
      mem_wdata = '0;
    end else if (commit) begin
      mem_we = 1'b1;
    end
  end

  // row memory
  always_ff @(posedge clk) begin
    if (mem_we) begin
      row_mem[mem_waddr] <= mem_wdata;
    end
    if (q_pop) begin
      rd_row <= row_mem[q_item[TAG_W +: SET_W]];
    end
  end

  // item held while its row is read
  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur_addr <= q_item[TAG_W-1:0];
      cur_set  <= q_item[TAG_W +: SET_W];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_CLEAR;
      clr_idx       <= '0;
      out_valid     <= 1'b0;
      hits_so_far   <= '0;
      misses_so_far <= '0;
    end else begin
      case (state)
        ST_CLEAR: begin
          clr_idx <= clr_idx + SET_W'(1);
          if (clr_idx == SET_W'(MAX_SETS - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (q_pop) begin
            state <= ST_CMP;
          end
        end
        ST_CMP: begin
          if (commit) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase

      if (commit) begin
        out_valid <= 1'b1;
        if (is_hit) begin
          if (!(&hits_so_far)) begin
            hits_so_far <= hits_so_far + sac_pkg::CNT_W'(1);
          end
        end else begin
          if (!(&misses_so_far)) begin
            misses_so_far <= misses_so_far + sac_pkg::CNT_W'(1);
          end
        end
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      hit      <= is_hit;
      way_used <= sac_pkg::WAY_OUT_W'(way);
    end
  end

endmodule

### rtl/set_assoc_cache_hit_model.sv
// ----------------------------------------------------------------------------
// set_assoc_cache_hit_model
// tag-array model of a set-associative cache with fifo or lru replacement
// ----------------------------------------------------------------------------
//
//   channel  signals                               beat taken when
//   -------  ------------------------------------  -----------------------
//   input    in_valid, in_stall, address           in_valid && !in_stall
//   result   out_valid, out_stall, hit, way_used,  out_valid && !out_stall
//            hits_so_far, misses_so_far
//   config   cfg_valid, cfg_ready, cfg_index,      cfg_valid && cfg_ready
//            cfg_data
//
// the back part takes each beat through ST_IDLE, which reads the set row from
// the row memory, and ST_CMP, which compares tags and writes the row back; it
// takes no new beat until the last one is written back.
// after reset a clearing pass walks every row of the row memory, with
// in_stall held high; config writes are taken during it.
// the front classifies and queues up to two beats ahead of the back part; a
// stalled result holds the back part, and the front keeps taking beats until
// the queue is full.
// ----------------------------------------------------------------------------
module set_assoc_cache_hit_model #(
  parameter int MAX_SETS  = sac_pkg::MAX_SETS_DEF,
  parameter int MAX_WAYS  = sac_pkg::MAX_WAYS_DEF,
  parameter int ADDR_BITS = sac_pkg::ADDR_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  // input channel
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [sac_pkg::ADDR_W-1:0]        address,
  // result channel
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              hit,
  output logic [sac_pkg::WAY_OUT_W-1:0]     way_used,
  output logic [sac_pkg::CNT_W-1:0]         hits_so_far,
  output logic [sac_pkg::CNT_W-1:0]         misses_so_far,
  // config channel
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [sac_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [sac_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam int TAG_W  = (ADDR_BITS < sac_pkg::ADDR_W) ? ADDR_BITS : sac_pkg::ADDR_W;
  localparam int SET_W  = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
  localparam int ITEM_W = SET_W + TAG_W;

  sac_pkg::cfg_t    cfg;
  logic             clearing;
  logic             q_push;
  logic             q_pop;
  logic             q_full;
  logic             q_empty;
  logic [ITEM_W-1:0] q_in;
  logic [ITEM_W-1:0] q_out;

  // config registers, always ready; unknown indexes are dropped
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= sac_pkg::CFG_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        sac_pkg::REG_LINE_LOG2: cfg.line_log2 <= cfg_data;
        sac_pkg::REG_SETS_LOG2: cfg.sets_log2 <= cfg_data;
        sac_pkg::REG_WAYS:      cfg.ways      <= cfg_data;
        sac_pkg::REG_POLICY:    cfg.policy    <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  // front: trims the address and picks its set
  sac_front #(
    .MAX_SETS  (MAX_SETS),
    .ADDR_BITS (ADDR_BITS)
  ) u_front (
    .cfg      (cfg),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .address  (address),
    .q_full   (q_full),
    .clearing (clearing),
    .q_push   (q_push),
    .q_item   (q_in)
  );

  // queue of classified beats
  sac_queue #(
    .WIDTH (ITEM_W)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .din   (q_in),
    .full  (q_full),
    .pop   (q_pop),
    .dout  (q_out),
    .empty (q_empty)
  );

  // back: row lookup, replacement, counters and result register
  sac_back #(
    .MAX_SETS  (MAX_SETS),
    .MAX_WAYS  (MAX_WAYS),
    .ADDR_BITS (ADDR_BITS)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .q_empty       (q_empty),
    .q_item        (q_out),
    .q_pop         (q_pop),
    .clearing      (clearing),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .hit           (hit),
    .way_used      (way_used),
    .hits_so_far   (hits_so_far),
    .misses_so_far (misses_so_far)
  );

  // no beat gets in while the row memory is being cleared
  assert property (@(posedge clk) disable iff (rst) clearing |-> in_stall)
    else $error("input taken during clearing pass");

  // hit count moves only by one, on a fresh hit result
  assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && !$stable(hits_so_far)) |->
      (out_valid && hit && hits_so_far == $past(hits_so_far) + 32'd1))
    else $error("hit count moved without a hit");

  // miss count moves only by one, on a fresh miss result
  assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && !$stable(misses_so_far)) |->
      (out_valid && !hit && misses_so_far == $past(misses_so_far) + 32'd1))
    else $error("miss count moved without a miss");

  // one beat is never counted both ways
  assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> ($stable(hits_so_far) || $stable(misses_so_far)))
    else $error("hit and miss counts moved together");

endmodule

### sim/set_assoc_cache_hit_model_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// set_assoc_cache_hit_model_tb
// self-checking bench for the set-associative cache hit model
//
// shadow copy of tag array, valid bits, fill pointers and counters
// each result beat checked against the oldest pending expectation
// directed corner tests first, then random traffic under three idling mixes
// ----------------------------------------------------------------------------
module set_assoc_cache_hit_model_tb;

  logic                           clk       = 1'b0;
  logic                           rst       = 1'b1;
  logic                           in_valid  = 1'b0;
  logic                           in_stall;
  logic [sac_pkg::ADDR_W-1:0]     address   = '0;
  logic                           out_valid;
  logic                           out_stall = 1'b0;
  logic                           hit;
  logic [sac_pkg::WAY_OUT_W-1:0]  way_used;
  logic [sac_pkg::CNT_W-1:0]      hits_so_far;
  logic [sac_pkg::CNT_W-1:0]      misses_so_far;
  logic                           cfg_valid = 1'b0;
  logic                           cfg_ready;
  logic [sac_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [sac_pkg::CFG_DATA_W-1:0] cfg_data  = '0;

  set_assoc_cache_hit_model dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .address       (address),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .hit           (hit),
    .way_used      (way_used),
    .hits_so_far   (hits_so_far),
    .misses_so_far (misses_so_far),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  // 20 ns period
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // one expected result beat
  typedef struct {
    logic                          hit;
    logic [sac_pkg::WAY_OUT_W-1:0] way;
    logic [sac_pkg::CNT_W-1:0]     hits;
    logic [sac_pkg::CNT_W-1:0]     misses;
  } lookup_result_t;

  // shadow of the block: registers, tag array, fill pointers, counters
  sac_pkg::cfg_t              shadow_cfg = sac_pkg::CFG_RESET;
  logic [sac_pkg::ADDR_W-1:0] tag_mem   [sac_pkg::MAX_SETS_DEF*sac_pkg::MAX_WAYS_DEF];
  bit                         tag_valid [sac_pkg::MAX_SETS_DEF*sac_pkg::MAX_WAYS_DEF];
  int                         fill_ptr  [sac_pkg::MAX_SETS_DEF];
  logic [sac_pkg::CNT_W-1:0]  hit_total  = '0;
  logic [sac_pkg::CNT_W-1:0]  miss_total = '0;

  lookup_result_t pending_lookups [$];
  int             errors = 0;

  // idling mix, in percent of cycles
  int sender_idle_pct = 0;
  int recv_stall_pct  = 0;

  initial begin
    foreach (tag_valid[k]) tag_valid[k] = 1'b0;
    foreach (fill_ptr[k]) fill_ptr[k] = 0;
  end

  // --------------------------------------------------------------------------
  // shadow lookup: runs the access against the shadow tag array and queues
  // the result the block should report for it
  // --------------------------------------------------------------------------
  function automatic void lookup_tags(input logic [sac_pkg::ADDR_W-1:0] a);
    int                         shift;
    int                         s_log;
    int                         nw;
    int                         set_idx;
    int                         base;
    int                         cur;
    int                         p;
    bit                         found;
    logic [sac_pkg::ADDR_W-1:0] blk;
    logic [sac_pkg::ADDR_W-1:0] t;
    lookup_result_t             r;

    shift = shadow_cfg.line_log2;
    blk   = a >> shift;

    // set count clamps to what the array holds
    s_log = shadow_cfg.sets_log2;
    while (s_log > 0 && (1 << s_log) > sac_pkg::MAX_SETS_DEF) s_log--;

    // ways of zero act as one, anything above the array acts as the array
    nw = shadow_cfg.ways;
    if (nw == 0) nw = 1;
    if (nw > sac_pkg::MAX_WAYS_DEF) nw = sac_pkg::MAX_WAYS_DEF;

    set_idx = int'(blk & ((32'h1 << s_log) - 1));
    base    = set_idx * sac_pkg::MAX_WAYS_DEF;
    found   = 1'b0;
    cur     = 0;

    // highest matching way wins when several match
    for (int i = 0; i < nw; i++) begin
      if (tag_valid[base+i] && ((tag_mem[base+i] >> shift) == blk)) begin
        found = 1'b1;
        cur   = i;
      end
    end

    if (shadow_cfg.policy == sac_pkg::POL_FIFO) begin
      if (!found) begin
        // a pointer left beyond the ways in use falls back to way 0
        p = fill_ptr[set_idx];
        if (p >= nw) p = 0;
        tag_mem[base+p]   = a;
        tag_valid[base+p] = 1'b1;
        cur               = p;
        fill_ptr[set_idx] = (p + 1) % nw;
      end
    end else if (found) begin
      // lru hit: move to front, shift only the entries ahead of it
      t = tag_mem[base+cur];
      for (int i = cur; i > 0; i--) begin
        tag_mem[base+i]   = tag_mem[base+i-1];
        tag_valid[base+i] = tag_valid[base+i-1];
      end
      tag_mem[base]   = t;
      tag_valid[base] = 1'b1;
    end else begin
      // lru miss: shift the whole set down, new block in front
      for (int i = nw - 1; i > 0; i--) begin
        tag_mem[base+i]   = tag_mem[base+i-1];
        tag_valid[base+i] = tag_valid[base+i-1];
      end
      tag_mem[base]   = a;
      tag_valid[base] = 1'b1;
      cur             = 0;
    end

    // saturating totals
    if (found) begin
      if (hit_total != '1) hit_total++;
    end else begin
      if (miss_total != '1) miss_total++;
    end

    r.hit    = found;
    r.way    = sac_pkg::WAY_OUT_W'(cur);
    r.hits   = hit_total;
    r.misses = miss_total;
    pending_lookups.push_back(r);
  endfunction

  // --------------------------------------------------------------------------
  // handshake helpers
  // --------------------------------------------------------------------------

  // one address beat; valid stays up after the beat so the next one can
  // follow without a bubble
  task automatic send_address(input logic [sac_pkg::ADDR_W-1:0] a);
    while (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    address  <= a;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    lookup_tags(a);
  endtask

  // one register write; caller drops cfg_valid after the last one
  task automatic write_reg(input logic [sac_pkg::CFG_IDX_W-1:0] idx,
                           input logic [sac_pkg::CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      sac_pkg::REG_LINE_LOG2: shadow_cfg.line_log2 = val;
      sac_pkg::REG_SETS_LOG2: shadow_cfg.sets_log2 = val;
      sac_pkg::REG_WAYS:      shadow_cfg.ways      = val;
      sac_pkg::REG_POLICY:    shadow_cfg.policy    = val[0];
      default: ;
    endcase
  endtask

  task automatic load_config(input logic [3:0] line_l, input logic [3:0] sets_l,
                             input logic [3:0] ways_n, input logic pol);
    write_reg(sac_pkg::REG_LINE_LOG2, line_l);
    write_reg(sac_pkg::REG_SETS_LOG2, sets_l);
    write_reg(sac_pkg::REG_WAYS, ways_n);
    write_reg(sac_pkg::REG_POLICY, {3'b000, pol});
    cfg_valid <= 1'b0;
  endtask

  // wait out every pending result, then the pipe latency, so the block is
  // idle before the next register write
  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_lookups.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // result side: random stall and the beat checker
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  always @(posedge clk) begin
    lookup_result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_lookups.size() == 0) begin
        $error("result beat with no lookup pending");
        errors++;
      end else begin
        want = pending_lookups.pop_front();
        if (hit !== want.hit) begin
          $error("hit: expected %0d, got %0d", want.hit, hit);
          errors++;
        end
        if (way_used !== want.way) begin
          $error("way_used: expected %0d, got %0d", want.way, way_used);
          errors++;
        end
        if (hits_so_far !== want.hits) begin
          $error("hits_so_far: expected %0d, got %0d", want.hits, hits_so_far);
          errors++;
        end
        if (misses_so_far !== want.misses) begin
          $error("misses_so_far: expected %0d, got %0d", want.misses, misses_so_far);
          errors++;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // directed tests
  // --------------------------------------------------------------------------

  // lowest and highest addresses under the reset settings, then the same
  // lines again at other byte offsets
  task automatic test_field_extremes();
    send_address(32'h0000_0000);
    send_address(32'hFFFF_FFFF);
    send_address(32'h0000_000F);
    send_address(32'hFFFF_FFF0);
    drain_results();
  endtask

  // fifo round robin in set 0: fill the remaining ways, then evict twice
  task automatic test_fifo_replacement();
    send_address(32'h0000_0400);
    send_address(32'h0000_0800);
    send_address(32'h0000_0C00);
    send_address(32'h0000_1000);
    send_address(32'h0000_0000);
    drain_results();
  endtask

  // switch to lru with the fifo-built set still in place: hit deep in the
  // set, miss, then hit on a moved entry
  task automatic test_lru_replacement();
    load_config(4'd4, 4'd6, 4'd4, sac_pkg::POL_LRU);
    send_address(32'h0000_0C00);
    send_address(32'h0000_2000);
    send_address(32'h0000_1000);
    drain_results();
  endtask

  // out-of-range register values and unused register indexes
  task automatic test_config_corners();
    // widest line, too many sets, ways of zero; policy from bit 0 only
    write_reg(sac_pkg::REG_LINE_LOG2, 4'd15);
    write_reg(sac_pkg::REG_SETS_LOG2, 4'd15);
    write_reg(sac_pkg::REG_WAYS, 4'd0);
    write_reg(sac_pkg::REG_POLICY, 4'b0010);
    // writes to unused indexes must change nothing
    for (int i = sac_pkg::REG_POLICY + 1; i < (1 << sac_pkg::CFG_IDX_W); i++)
      write_reg(sac_pkg::CFG_IDX_W'(i), 4'hF);
    cfg_valid <= 1'b0;
    send_address(32'h1234_5678);
    send_address(32'h1234_0001);
    drain_results();

    // byte lines, ways above the array, lru with upper data bits set
    write_reg(sac_pkg::REG_LINE_LOG2, 4'd0);
    write_reg(sac_pkg::REG_SETS_LOG2, 4'd9);
    write_reg(sac_pkg::REG_WAYS, 4'd15);
    write_reg(sac_pkg::REG_POLICY, 4'b1101);
    cfg_valid <= 1'b0;
    send_address(32'hA5A5_A5A5);
    send_address(32'h5A5A_5A5A);
    drain_results();
  endtask

  // fifo pointer left past the ways in use after the way count shrinks
  task automatic test_fifo_pointer_wrap();
    // set 200 is untouched so far, its pointer starts at zero
    load_config(4'd3, 4'd8, 4'd8, sac_pkg::POL_FIFO);
    send_address(32'h0000_0640);
    send_address(32'h0000_0E40);
    send_address(32'h0000_1640);
    drain_results();
    load_config(4'd3, 4'd8, 4'd2, sac_pkg::POL_FIFO);
    send_address(32'h0000_1E40);
    drain_results();
  endtask

  // two byte-distinct blocks merge into one when the line grows
  task automatic test_multiple_matches();
    load_config(4'd0, 4'd0, 4'd8, sac_pkg::POL_FIFO);
    send_address(32'h0000_0100);
    send_address(32'h0000_0101);
    drain_results();
    write_reg(sac_pkg::REG_LINE_LOG2, 4'd4);
    cfg_valid <= 1'b0;
    send_address(32'h0000_0100);
    drain_results();
  endtask

  // --------------------------------------------------------------------------
  // random traffic under one setting; most beats revisit recent lines or
  // aliases in the same set so hits, evictions and reorders all happen
  // --------------------------------------------------------------------------
  task automatic test_random_traffic(input int n_items, input logic [3:0] line_l,
                                     input logic [3:0] sets_l, input logic [3:0] ways_n,
                                     input logic pol);
    logic [sac_pkg::ADDR_W-1:0] recent [16];
    logic [sac_pkg::ADDR_W-1:0] a;
    logic [sac_pkg::ADDR_W-1:0] line_mask;
    int                         set_b;
    int                         roll;
    int                         k;

    load_config(line_l, sets_l, ways_n, pol);
    set_b     = (sets_l > 8) ? 8 : sets_l;
    line_mask = (32'h1 << line_l) - 1;
    foreach (recent[j]) recent[j] = $urandom;

    for (int n = 0; n < n_items; n++) begin
      roll = $urandom_range(99);
      k    = $urandom_range(15);
      if (roll < 55) begin
        // same block, other byte
        a = recent[k] ^ (32'($urandom) & line_mask);
      end else begin
        if (roll < 85)
          a = recent[k] + (32'($urandom_range(1, 3)) << (line_l + set_b));
        else
          a = $urandom;
        recent[$urandom_range(15)] = a;
      end
      send_address(a);
    end
    drain_results();
  endtask

  // --------------------------------------------------------------------------
  // sequence
  // --------------------------------------------------------------------------
  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    test_field_extremes();
    test_fifo_replacement();
    test_lru_replacement();
    test_config_corners();
    test_fifo_pointer_wrap();
    test_multiple_matches();

    // sender rarely idle, receiver mostly stalled
    sender_idle_pct = 12;
    recv_stall_pct  = 71;
    test_random_traffic(70, 4'd4, 4'd6, 4'd4, sac_pkg::POL_FIFO);
    test_random_traffic(70, 4'd0, 4'd0, 4'd1, sac_pkg::POL_LRU);
    test_random_traffic(70, 4'd12, 4'd8, 4'd8, sac_pkg::POL_LRU);
    test_random_traffic(70, 4'd2, 4'd2, 4'd3, sac_pkg::POL_FIFO);

    // sender mostly idle, receiver rarely stalled
    sender_idle_pct = 71;
    recv_stall_pct  = 12;
    test_random_traffic(70, 4'd15, 4'd15, 4'd15, sac_pkg::POL_LRU);
    test_random_traffic(70, 4'd1, 4'd1, 4'd2, sac_pkg::POL_FIFO);
    test_random_traffic(70, 4'd5, 4'd3, 4'd8, sac_pkg::POL_FIFO);
    test_random_traffic(70, 4'd0, 4'd4, 4'd0, sac_pkg::POL_LRU);

    // back to back, no idling on either side
    sender_idle_pct = 0;
    recv_stall_pct  = 0;
    test_random_traffic(70, 4'd3, 4'd2, 4'd5, sac_pkg::POL_LRU);
    test_random_traffic(70, 4'd12, 4'd0, 4'd8, sac_pkg::POL_FIFO);
    test_random_traffic(70, 4'($urandom_range(15)), 4'($urandom_range(15)),
                        4'($urandom_range(15)), 1'($urandom_range(1)));
    test_random_traffic(70, 4'd6, 4'd5, 4'd6, sac_pkg::POL_LRU);

    if (errors == 0 && pending_lookups.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // hang guard, far beyond the slowest legal run
  initial begin
    #2_000_000;
    $display("status: fail");
    $finish;
  end

endmodule
